@@ rtl/mast_pkg.sv @@
// Shared types and constants for the MAC address sighting table.
// Used by the interfaces, the controller, the datapath and the top level.
package mast_pkg;

  localparam int ADDR_W = 48;
  localparam int STR_W = 8;
  localparam int TIME_W = 32;
  localparam int IDX_W = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic resolve;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic full;
    logic out_busy;
  } ctrl_sts_t;

endpackage

@@ rtl/mast_if.sv @@
// Valid/ready channel interfaces for sightings in and results out.
// Depends on mast_pkg for the field widths.
interface mast_sighting_if import mast_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] mac_address;
  logic [STR_W-1:0]  signal_strength;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, mac_address, signal_strength, now_ms, input ready);
  modport sink (input valid, mac_address, signal_strength, now_ms, output ready);
endinterface

interface mast_result_if import mast_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  entry_index;
  logic              is_new;
  logic              dropped;
  logic [TIME_W-1:0] interval_ms;

  modport source (output valid, entry_index, is_new, dropped, interval_ms, input ready);
  modport sink (input valid, entry_index, is_new, dropped, interval_ms, output ready);
endinterface

@@ rtl/mast_ctrl.sv @@
// Controller state machine of the sighting table: sequences scan, lookup and update.
// Depends on mast_pkg for the state type and the command and status structs.
module mast_ctrl import mast_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.hit) begin
          state_next = ST_LOOKUP;
        end else if (sts.miss) begin
          state_next = sts.full ? ST_UPDATE : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!sts.out_busy) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.start = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        cmd.resolve = sts.hit | sts.miss;
      end
      ST_LOOKUP: begin
      end
      ST_UPDATE: begin
        cmd.commit = !sts.out_busy;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/mast_datapath.sv @@
// Datapath of the sighting table: entry memories, scan pipeline and result register.
// Depends on mast_pkg for widths and the command and status structs.
module mast_datapath import mast_pkg::*; #(
  parameter int ENTRIES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  output ctrl_sts_t         sts,
  input  logic [ADDR_W-1:0] mac_address,
  input  logic [STR_W-1:0]  signal_strength,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              res_ready,
  output logic              res_valid,
  output logic [IDX_W-1:0]  entry_index,
  output logic              is_new,
  output logic              dropped,
  output logic [TIME_W-1:0] interval_ms
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [ADDR_W-1:0] addr_mem [ENTRIES];
  logic [STR_W-1:0]  str_mem  [ENTRIES];
  logic [TIME_W-1:0] last_mem [ENTRIES];
  logic [TIME_W-1:0] prev_mem [ENTRIES];

  logic [ADDR_W-1:0] addr_q;
  logic [STR_W-1:0]  strength_q;
  logic [TIME_W-1:0] now_q;
  logic [CW-1:0]     count;
  logic [CW-1:0]     rd_idx;
  logic              cmp_valid;
  logic [IW-1:0]     cmp_idx;
  logic [ADDR_W-1:0] addr_rdata;
  logic [IW-1:0]     slot;
  logic              slot_new;
  logic              slot_drop;
  logic [TIME_W-1:0] last_rdata;
  logic [TIME_W-1:0] last_base;
  logic              out_valid;
  logic              hit;
  logic              full;

  assign hit = cmp_valid && (addr_rdata == addr_q);
  assign full = (count == CW'(ENTRIES));
  assign last_base = slot_new ? '0 : last_rdata;

  assign sts.hit = hit;
  assign sts.miss = !cmp_valid && (rd_idx >= count);
  assign sts.full = full;
  assign sts.out_busy = out_valid && !res_ready;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      addr_q <= mac_address;
      strength_q <= signal_strength;
      now_q <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      cmp_valid <= 1'b0;
    end else if (cmd.start) begin
      rd_idx <= '0;
      cmp_valid <= 1'b0;
    end else if (cmd.scan) begin
      if (rd_idx < count) begin
        rd_idx <= rd_idx + 1'b1;
        cmp_valid <= 1'b1;
      end else begin
        cmp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= rd_idx[IW-1:0];
    addr_rdata <= addr_mem[rd_idx[IW-1:0]];
    last_rdata <= last_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      slot <= hit ? cmp_idx : count[IW-1:0];
      slot_new <= !hit && !full;
      slot_drop <= !hit && full;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !slot_drop) begin
      str_mem[slot] <= strength_q;
      last_mem[slot] <= now_q;
      prev_mem[slot] <= last_base;
      if (slot_new) begin
        addr_mem[slot] <= addr_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit && slot_new) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (res_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      entry_index <= slot_drop ? '0 : IDX_W'(slot);
      is_new <= slot_new;
      dropped <= slot_drop;
      interval_ms <= slot_drop ? '0 : (now_q - last_base);
    end
  end

  assign res_valid = out_valid;

endmodule

@@ rtl/mac_address_sighting_table_top.sv @@
// Top level of the MAC address sighting table: controller plus datapath.
// Depends on mast_pkg, mast_if, mast_ctrl and mast_datapath.
//
//   Channel    Dir  Fields
//   sighting   in   mac_address[47:0], signal_strength[7:0], now_ms[31:0]
//   result     out  entry_index[4:0], is_new, dropped, interval_ms[31:0]
//
// A request scans the filled entries until it hits or runs past the fill count, then goes
// through LOOKUP to UPDATE; a hit on entry k ends the scan at that entry.
// A miss on a full table goes from SCAN straight to UPDATE and the request is dropped.
// The scan reads the address memory one entry per cycle, and the next request is taken
// in the cycle after the result is written.
// Reset clears the fill count and the control state; no clearing pass is needed.
// A new request is taken while a result waits in the output register; the update stalls
// only when that register is still occupied.
module mac_address_sighting_table_top import mast_pkg::*; #(
  parameter int ENTRIES = 32
) (
  input logic      clk,
  input logic      rst,
  mast_sighting_if.sink sighting,
  mast_result_if.source result
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  mast_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sighting.valid),
    .in_ready (sighting.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mast_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .mac_address     (sighting.mac_address),
    .signal_strength (sighting.signal_strength),
    .now_ms          (sighting.now_ms),
    .res_ready       (result.ready),
    .res_valid       (result.valid),
    .entry_index     (result.entry_index),
    .is_new          (result.is_new),
    .dropped         (result.dropped),
    .interval_ms     (result.interval_ms)
  );

endmodule
